// ----- rtl/base32_stream_encoder_core_assert.svh -----
// Assertion macros shared by the base32 encoder modules.
`ifndef BASE32_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE32_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define B32E_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define B32E_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/b32e_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_pkg
// Types and constants shared by the base32 stream encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int GROUP_W   = 5;
  localparam int MAX_CHARS = 3;
  localparam int IDX_W     = 2;
  localparam int CNT_W     = 3;
  localparam int PEND_W    = 4;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  // '2' minus 26, so the digit range maps from group values 26 to 31.
  localparam logic [7:0] ASCII_DIGIT_BASE = 8'h18;
  localparam logic [4:0] LETTER_COUNT = 5'd26;

  // One byte after classification: its characters and how to flag them.
  typedef struct packed {
    logic [MAX_CHARS-1:0][GROUP_W-1:0] groups;
    logic [IDX_W-1:0]                  last_idx;
    logic                              final_word;
  } b32e_job_t;

  function automatic logic [7:0] b32_char(input logic [GROUP_W-1:0] g);
    logic [7:0] code;
    if (g < LETTER_COUNT) begin
      code = ASCII_UPPER_A + {3'b000, g};
    end else begin
      code = ASCII_DIGIT_BASE + {3'b000, g};
    end
    return code;
  endfunction

endpackage

// ----- rtl/b32e_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_front
// Accepts message bytes, merges them with the leftover bits and splits the
// result into 5-bit groups for the back end.
// ----------------------------------------------------------------------------
`include "base32_stream_encoder_core_assert.svh"

module b32e_front
  import b32e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_final,
  output logic       push,
  output b32e_job_t  push_job,
  input  logic       queue_full
);

  logic [PEND_W-1:0] pending_bits;
  logic [CNT_W-1:0]  pending_count;
  logic [PEND_W-1:0] pending_bits_next;
  logic [CNT_W-1:0]  pending_count_next;

  logic [11:0] acc;
  logic [11:0] aligned;
  logic [14:0] window;
  logic [CNT_W-1:0] shift;
  logic [CNT_W-1:0] rem;
  logic        two_full;
  logic        has_tail;
  logic [PEND_W-1:0] rem_mask;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    acc      = {pending_bits, data_byte};
    // Left-justify the valid bits so the groups come off the top.
    shift    = 3'd4 - pending_count;
    aligned  = acc << shift;
    window   = {aligned, 3'b000};
    two_full = pending_count >= 3'd2;
    rem      = two_full ? (pending_count - 3'd2) : (pending_count + 3'd3);
    has_tail = is_final && (rem != 3'd0);
    rem_mask = ~(4'hF << rem);

    push_job.groups[0]  = window[14:10];
    push_job.groups[1]  = window[9:5];
    push_job.groups[2]  = window[4:0];
    push_job.final_word = is_final;
    if (two_full) begin
      push_job.last_idx = has_tail ? 2'd2 : 2'd1;
    end else begin
      push_job.last_idx = has_tail ? 2'd1 : 2'd0;
    end

    if (is_final) begin
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next  = acc[PEND_W-1:0] & rem_mask;
      pending_count_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (push) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  `B32E_ASSERT_NOW(a_count_range, clk, rst, 1'b1, pending_count <= 3'd4, "leftover count above 4")
  `B32E_ASSERT_NEXT(a_final_clears, clk, rst, push && is_final, pending_count == 3'd0, "store not cleared after final byte")

endmodule

// ----- rtl/b32e_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`include "base32_stream_encoder_core_assert.svh"

module b32e_queue
  import b32e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b32e_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output b32e_job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b32e_job_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == FULL_CNT;
  assign not_empty = count != '0;
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `B32E_ASSERT_NOW(a_queue_bounds, clk, rst, 1'b1, (count <= FULL_CNT) && !(pop && !not_empty), "queue overflow or underflow")

endmodule

// ----- rtl/b32e_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_back
// Takes classified bytes from the queue and issues their characters, one
// per cycle while out_ready allows, through a registered output.
// ----------------------------------------------------------------------------
`include "base32_stream_encoder_core_assert.svh"

module b32e_back
  import b32e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_avail,
  input  b32e_job_t  next_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_code,
  output logic       run_end,
  output logic       message_end
);

  b32e_job_t        job;
  logic             job_valid;
  logic [IDX_W-1:0] idx;
  logic             load_out;
  logic             at_last;
  logic             issue;

  assign load_out = !out_valid || out_ready;
  assign at_last  = idx == job.last_idx;
  assign issue    = job_valid && load_out;
  assign pop      = job_avail && (!job_valid || (issue && at_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= next_job;
    end
    if (issue) begin
      char_code   <= b32_char(job.groups[idx]);
      run_end     <= at_last;
      message_end <= at_last && job.final_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        job_valid <= 1'b1;
        idx       <= '0;
      end else if (issue) begin
        if (at_last) begin
          job_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `B32E_ASSERT_NOW(a_msg_end_on_run_end, clk, rst, out_valid && message_end, run_end, "message end without run end")
  `B32E_ASSERT_NOW(a_idx_in_job, clk, rst, job_valid, idx <= job.last_idx, "character index past end of byte")

endmodule

// ----- rtl/base32_stream_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_encoder_core
// Unpadded base32 encoder: one message byte in, one to three alphabet
// characters out, leftover bits carried between bytes.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Word
// input    in         in_valid / in_ready   data_byte, is_final
// output   out        out_valid / out_ready char_code, run_end, message_end
//
// The back end issues one character per cycle while out_ready allows, and a
// byte yields one to three (1.6 on average); that output register sets the rate.
// The front end takes a byte per cycle while the queue has room.
// A byte passes the queue, the job register and the output register in turn.
// Reset clears the leftover store, the queue and the output.
// A stalled output fills the queue, after which in_ready drops.
// ----------------------------------------------------------------------------
module base32_stream_encoder_core
  import b32e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_code,
  output logic       run_end,
  output logic       message_end
);

  logic      push;
  b32e_job_t push_job;
  logic      queue_full;
  logic      pop;
  logic      queue_not_empty;
  b32e_job_t pop_job;

  b32e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .pop_job   (pop_job)
  );

  b32e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_avail   (queue_not_empty),
    .next_job    (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .run_end     (run_end),
    .message_end (message_end)
  );

endmodule

// ----- test/base32_stream_encoder_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_encoder_core_test
// Self-checking bench for the unpadded base32 stream encoder. A driver feeds
// message bytes from a queue, and a monitor predicts every character from its
// own copy of the leftover bit store and compares what the block emits.
// Idling on both channels changes over four phases of the run.
// ----------------------------------------------------------------------------
module base32_stream_encoder_core_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 450;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] code;
    logic       run_end;
    logic       message_end;
  } b32_symbol_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       is_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] char_code;
  logic       run_end;
  logic       message_end;

  msg_byte_t   byte_q[$];
  b32_symbol_t symbol_q[$];

  // Predicted leftover store of the encoder.
  logic [3:0] carry_bits = 4'h0;
  int         carry_count = 0;

  int n_accepted = 0;
  int n_total = 1;
  int n_errors = 0;
  int n_cycles = 0;

  base32_stream_encoder_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .run_end    (run_end),
    .message_end(message_end)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] symbol_of(input logic [4:0] group);
    logic [7:0] code;
    if (group < 5'd26) begin
      code = "A" + {3'b000, group};
    end else begin
      code = "2" + {3'b000, group - 5'd26};
    end
    return code;
  endfunction

  // Phase 0 has no idling; 1 idles the sender, 2 stalls the receiver, 3 both.
  function automatic int idle_phase();
    int ph;
    ph = (n_accepted * 4) / n_total;
    if (ph > 3) begin
      ph = 3;
    end
    return ph;
  endfunction

  function automatic bit sender_idle();
    int ph;
    ph = idle_phase();
    if (ph == 1) begin
      return $urandom_range(0, 99) < 52;
    end else if (ph == 3) begin
      return $urandom_range(0, 99) < 32;
    end
    return 1'b0;
  endfunction

  function automatic bit receiver_stall();
    int ph;
    ph = idle_phase();
    if (ph == 2) begin
      return $urandom_range(0, 99) < 52;
    end else if (ph == 3) begin
      return $urandom_range(0, 99) < 32;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", n_cycles, what);
    n_errors++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    msg_byte_t item;
    item.data = data;
    item.last = last;
    byte_q.push_back(item);
  endtask

  // Appends one byte to the predicted store and queues the characters it causes.
  task automatic encode_byte(input logic [7:0] data, input logic last);
    logic [11:0] acc;
    b32_symbol_t out_sym[3];
    int nbits;
    int k;
    acc = {carry_bits, data};
    nbits = carry_count + 8;
    k = 0;
    while (nbits >= 5) begin
      out_sym[k] = '{code: symbol_of(5'(acc >> (nbits - 5))), run_end: 1'b0,
                     message_end: 1'b0};
      k++;
      nbits -= 5;
    end
    acc &= (12'd1 << nbits) - 12'd1;
    if (last) begin
      if (nbits > 0) begin
        out_sym[k] = '{code: symbol_of(5'(acc << (5 - nbits))), run_end: 1'b0,
                       message_end: 1'b0};
        k++;
      end
      acc = '0;
      nbits = 0;
    end
    carry_bits = acc[3:0];
    carry_count = nbits;
    out_sym[k-1].run_end = 1'b1;
    out_sym[k-1].message_end = last;
    for (int i = 0; i < k; i++) begin
      symbol_q.push_back(out_sym[i]);
    end
  endtask

  // Driver: a new word is offered only once the current one has been taken.
  always @(posedge clk) begin
    msg_byte_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_q.size() != 0 && !sender_idle()) begin
        item = byte_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= item.data;
        is_final <= item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: outputs are checked before this edge's input is predicted, since
  // a word accepted now cannot have caused a character at the same edge.
  always @(posedge clk) begin
    b32_symbol_t got;
    b32_symbol_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_stall();
      if (out_valid && out_ready) begin
        got = '{code: char_code, run_end: run_end, message_end: message_end};
        if (symbol_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h run_end %b message_end %b",
                                    got.code, got.run_end, got.message_end));
        end else begin
          want = symbol_q.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "char %h/%h run_end %b/%b message_end %b/%b (got/expected)",
              got.code, want.code, got.run_end, want.run_end,
              got.message_end, want.message_end));
          end
        end
      end
      if (in_valid && in_ready) begin
        encode_byte(data_byte, is_final);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("FAIL base32_stream_encoder_core");
      $finish;
    end
  end

  initial begin
    int n_random;
    int len;
    // Single-byte messages at the extremes: one full group plus a 3-bit flush.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b1);
    // Messages of two to five bytes leave 1, 4, 2 and 0 bits to flush; five
    // bytes divide evenly, so no extra character follows the last group.
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // A message left open carries its leftover bits into the random part.
    push_byte(8'hC3, 1'b0);

    n_random = 0;
    while (n_random < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      for (int j = 0; j < len; j++) begin
        push_byte(8'($urandom_range(0, 255)), j == len - 1);
      end
      n_random += len;
    end
    n_total = byte_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (symbol_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("PASS base32_stream_encoder_core");
    end else begin
      $display("FAIL base32_stream_encoder_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/b32e_pkg.sv
rtl/b32e_front.sv
rtl/b32e_queue.sv
rtl/b32e_back.sv
rtl/base32_stream_encoder_core.sv
test/base32_stream_encoder_core_test.sv
